>>> sv/dthp_pkg.sv
// Shared types, constants and the signature lookup for the track-info header parser.
// No dependencies; every other file except the config register refers to this package by scoped names.
package dthp_pkg;

	localparam int unsigned SECTOR_CAP = 29;
	localparam int unsigned IDX_W = 5;
	localparam int unsigned POS_W = 9;

	localparam logic [POS_W-1:0] POS_SIG_END = 9'h00C;
	localparam logic [POS_W-1:0] POS_COUNT   = 9'h015;
	localparam logic [POS_W-1:0] POS_GAP     = 9'h016;
	localparam logic [POS_W-1:0] POS_FILLER  = 9'h017;
	localparam logic [POS_W-1:0] POS_ENTRY   = 9'h018;
	localparam logic [POS_W-1:0] POS_MAX     = 9'h1FF;

	localparam logic [23:0] DATA_BIAS = 24'h000100;
	localparam logic [15:0] STD_SIZE_BASE = 16'd128;
	localparam logic [7:0] LEN_CODE_MAX = 8'd8;

	localparam logic [1:0] KIND_HEADER = 2'd0;
	localparam logic [1:0] KIND_SECTOR = 2'd1;
	localparam logic [1:0] KIND_ERROR  = 2'd2;

	typedef struct packed {
		logic [7:0]  data_byte;
		logic        block_start;
		logic [23:0] base_offset;
	} in_t;

	typedef struct packed {
		logic [1:0]  kind;
		logic [7:0]  sec_total;
		logic [7:0]  gap_length;
		logic [7:0]  filler_byte;
		logic [7:0]  track_id;
		logic [7:0]  side_id;
		logic [7:0]  sec_ident;
		logic [7:0]  len_code;
		logic [15:0] fdc_status;
		logic [15:0] sec_bytes;
		logic [23:0] sec_offset;
		logic        last;
	} out_t;

	function automatic logic [7:0] sig_byte(input logic [3:0] idx);
		logic [7:0] b;
		begin
			unique case (idx)
				4'd0: b = 8'h54;
				4'd1: b = 8'h72;
				4'd2: b = 8'h61;
				4'd3: b = 8'h63;
				4'd4: b = 8'h6B;
				4'd5: b = 8'h2D;
				4'd6: b = 8'h49;
				4'd7: b = 8'h6E;
				4'd8: b = 8'h66;
				4'd9: b = 8'h6F;
				4'd10: b = 8'h0D;
				4'd11: b = 8'h0A;
				default: b = 8'h00;
			endcase
			return b;
		end
	endfunction

endpackage

>>> sv/dsk_track_header_parser_core.sv
// Top level of the track-info block parser: input register, parse stage, config register.
// Depends on dthp_pkg, dthp_in_stage, dthp_parse and dthp_cfg_reg.
//
//   channel | signals                          | beat
//   in      | in_valid, in_ready, in_data      | one block byte with start flag and base
//   out     | out_valid, out_ready, out_data   | header, sector descriptor or error
//   cfg     | cfg_valid, cfg_ready, cfg_data   | extended_mode bit
//
// One byte per cycle sustained while results are not stalled; a byte that yields a result
// passes the input register and then the result register before it is presented.
// Reset clears block state, the mode bit and both valid flags; entry bytes are not reset.
// A stalled result holds the parse stage; one more byte waits in the input register.
module dsk_track_header_parser_core (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           in_valid,
	output logic           in_ready,
	input  dthp_pkg::in_t  in_data,
	output logic           out_valid,
	input  logic           out_ready,
	output dthp_pkg::out_t out_data,
	input  logic           cfg_valid,
	output logic           cfg_ready,
	input  logic           cfg_data
);

	logic          valid_s1;
	dthp_pkg::in_t data_s1;
	logic          advance;
	logic          extended_mode;

	dthp_cfg_reg u_cfg (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_data      (cfg_data),
		.extended_mode (extended_mode)
	);

	dthp_in_stage u_in (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.in_data  (in_data),
		.advance  (advance),
		.valid_s1 (valid_s1),
		.data_s1  (data_s1)
	);

	dthp_parse u_parse (
		.clk           (clk),
		.arst_n        (arst_n),
		.extended_mode (extended_mode),
		.valid_s1      (valid_s1),
		.data_s1       (data_s1),
		.advance       (advance),
		.out_valid     (out_valid),
		.out_ready     (out_ready),
		.out_data      (out_data)
	);

endmodule

>>> sv/dthp_in_stage.sv
// Track-info header parser input register: one byte beat per cycle unless stalled.
// Depends on dthp_pkg for the input beat type.
module dthp_in_stage (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	output logic          in_ready,
	input  dthp_pkg::in_t in_data,
	input  logic          advance,
	output logic          valid_s1,
	output dthp_pkg::in_t data_s1
);

	assign in_ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			data_s1 <= in_data;
		end
	end

endmodule

>>> sv/dthp_parse.sv
// Parse stage: block state, entry byte store and the registered result beat.
// Depends on dthp_pkg for types, offsets, result kinds and the signature table.
module dthp_parse (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           extended_mode,
	input  logic           valid_s1,
	input  dthp_pkg::in_t  data_s1,
	output logic           advance,
	output logic           out_valid,
	input  logic           out_ready,
	output dthp_pkg::out_t out_data
);

	logic [dthp_pkg::POS_W-1:0] pos_q;
	logic                       active_q;
	logic [7:0]                 count_q;
	logic [dthp_pkg::IDX_W-1:0] index_q;
	logic [23:0]                acc_q;
	logic [7:0]                 entry_q [0:6];

	logic [dthp_pkg::POS_W-1:0] pos_c;
	logic                       active_c;
	logic [7:0]                 count_c;
	logic [dthp_pkg::IDX_W-1:0] index_c;
	logic [23:0]                acc_c;

	logic [dthp_pkg::POS_W-1:0] pos_n;
	logic                       active_n;
	logic [7:0]                 count_n;
	logic [dthp_pkg::IDX_W-1:0] index_n;
	logic [23:0]                acc_n;
	logic                       store_we;
	logic [2:0]                 store_idx;

	logic [dthp_pkg::IDX_W-1:0] limit;
	logic [dthp_pkg::IDX_W-1:0] index_inc;
	logic [3:0]                 code_sat;
	logic [15:0]                size;
	logic                       has_result;
	dthp_pkg::out_t             result;
	logic [7:0]                 b;

	assign advance = valid_s1 && (!out_valid || out_ready);
	assign b = data_s1.data_byte;

	always_comb begin
		if (data_s1.block_start) begin
			pos_c = '0;
			active_c = 1'b1;
			count_c = '0;
			index_c = '0;
			acc_c = data_s1.base_offset + dthp_pkg::DATA_BIAS;
		end else begin
			pos_c = pos_q;
			active_c = active_q;
			count_c = count_q;
			index_c = index_q;
			acc_c = acc_q;
		end
	end

	always_comb begin
		if (count_c < 8'(dthp_pkg::SECTOR_CAP)) begin
			limit = count_c[dthp_pkg::IDX_W-1:0];
		end else begin
			limit = dthp_pkg::IDX_W'(dthp_pkg::SECTOR_CAP);
		end
		index_inc = index_c + dthp_pkg::IDX_W'(1);
		if (entry_q[3] > dthp_pkg::LEN_CODE_MAX) begin
			code_sat = dthp_pkg::LEN_CODE_MAX[3:0];
		end else begin
			code_sat = entry_q[3][3:0];
		end
		if (extended_mode) begin
			size = {b, entry_q[6]};
		end else begin
			size = dthp_pkg::STD_SIZE_BASE << code_sat;
		end
	end

	always_comb begin
		pos_n = pos_c;
		active_n = active_c;
		count_n = count_c;
		index_n = index_c;
		acc_n = acc_c;
		store_we = 1'b0;
		store_idx = pos_c[2:0];
		has_result = 1'b0;
		result = '0;
		if (active_c) begin
			if (pos_c != dthp_pkg::POS_MAX) begin
				pos_n = pos_c + dthp_pkg::POS_W'(1);
			end
			priority if (pos_c < dthp_pkg::POS_SIG_END) begin
				if (b != dthp_pkg::sig_byte(pos_c[3:0])) begin
					active_n = 1'b0;
					has_result = 1'b1;
					result.kind = dthp_pkg::KIND_ERROR;
					result.last = 1'b1;
				end
			end else if (pos_c == dthp_pkg::POS_COUNT) begin
				count_n = b;
			end else if (pos_c == dthp_pkg::POS_GAP) begin
				store_we = 1'b1;
				store_idx = 3'd0;
			end else if (pos_c == dthp_pkg::POS_FILLER) begin
				has_result = 1'b1;
				result.kind = dthp_pkg::KIND_HEADER;
				result.sec_total = count_c;
				result.gap_length = entry_q[0];
				result.filler_byte = b;
				result.last = (limit == '0);
				if (limit == '0) begin
					active_n = 1'b0;
				end
			end else if (pos_c >= dthp_pkg::POS_ENTRY) begin
				if (pos_c[2:0] != 3'd7) begin
					store_we = 1'b1;
				end else begin
					has_result = 1'b1;
					result.kind = dthp_pkg::KIND_SECTOR;
					result.track_id = entry_q[0];
					result.side_id = entry_q[1];
					result.sec_ident = entry_q[2];
					result.len_code = entry_q[3];
					result.fdc_status = {entry_q[5], entry_q[4]};
					result.sec_bytes = size;
					result.sec_offset = acc_c;
					acc_n = acc_c + 24'(size);
					index_n = index_inc;
					if (index_inc >= limit) begin
						result.last = 1'b1;
						active_n = 1'b0;
					end
				end
			end else begin
				has_result = 1'b0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q <= '0;
			active_q <= 1'b0;
			count_q <= '0;
			index_q <= '0;
			acc_q <= '0;
			out_valid <= 1'b0;
		end else begin
			if (advance) begin
				pos_q <= pos_n;
				active_q <= active_n;
				count_q <= count_n;
				index_q <= index_n;
				acc_q <= acc_n;
				out_valid <= has_result;
			end else if (out_ready) begin
				out_valid <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (advance && store_we) begin
			entry_q[store_idx] <= b;
		end
		if (advance && has_result) begin
			out_data <= result;
		end
	end

endmodule

>>> sv/dthp_track_header_parser_core_dummy_guard.sv
// Configuration register of the track-info header parser: holds the sector size mode.
// No package dependency; used by the top level.
module dthp_cfg_reg (
	input  logic clk,
	input  logic arst_n,
	input  logic cfg_valid,
	output logic cfg_ready,
	input  logic cfg_data,
	output logic extended_mode
);

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			extended_mode <= 1'b0;
		end else if (cfg_valid && cfg_ready) begin
			extended_mode <= cfg_data;
		end
	end

endmodule
